// ===== sv/noise_channel_lfsr_envelope_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the noise channel
// Concurrent checks sampled on clk, switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef NOISE_CHANNEL_LFSR_ENVELOPE_ASSERT_SVH
`define NOISE_CHANNEL_LFSR_ENVELOPE_ASSERT_SVH

// same-cycle implication
`define NCLE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication into the next cycle
`define NCLE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/ncle_pkg.sv =====
// ----------------------------------------------------------------------------
// ncle_pkg
// Shared types, codes, constants and helper functions of the noise channel.
// ----------------------------------------------------------------------------
package ncle_pkg;

    typedef enum logic [2:0] {
        OP_WRITE    = 3'd0,
        OP_READ     = 3'd1,
        OP_ADVANCE  = 3'd2,
        OP_LEN_TICK = 3'd3,
        OP_ENV_TICK = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        REG_LENGTH   = 2'd0,
        REG_ENVELOPE = 2'd1,
        REG_FREQ     = 2'd2,
        REG_CONTROL  = 2'd3
    } reg_idx_t;

    localparam int          LENGTH_LIMIT = 64;
    localparam logic [7:0]  DAC_MASK     = 8'b1111_1000;
    localparam logic [7:0]  READ_MASK    = 8'b0100_0000;
    localparam logic [15:0] LFSR_SEED    = 16'hFFFF;
    localparam logic [3:0]  VOLUME_MAX   = 4'd15;
    localparam logic [3:0]  VOLUME_MIN   = 4'd0;

    // divider result handed back to the top level
    typedef struct packed {
        logic [31:0] count_next;
        logic        step;
    } div_res_t;

    // base divisor, selected by freq_random[2:0]
    function automatic logic [6:0] divisor(input logic [2:0] sel);
        logic [6:0] d;
        case (sel)
            3'd0:    d = 7'd8;
            3'd1:    d = 7'd16;
            3'd2:    d = 7'd32;
            3'd3:    d = 7'd48;
            3'd4:    d = 7'd64;
            3'd5:    d = 7'd80;
            3'd6:    d = 7'd96;
            default: d = 7'd112;
        endcase
        return d;
    endfunction

    // one LFSR shift; short mode also feeds bit 7
    function automatic logic [15:0] lfsr_step(input logic [15:0] s, input logic short_mode);
        logic        fb;
        logic [15:0] t;
        fb = s[0] ^ s[1];
        t  = {fb, s[14:0]};
        if (short_mode)
        begin
            t[7] = fb;
        end
        return {1'b0, t[15:1]};
    endfunction

endpackage

// ===== sv/noise_channel_lfsr_envelope.sv =====
// ----------------------------------------------------------------------------
// noise_channel_lfsr_envelope
// Noise sound channel: four byte registers, LFSR, length counter, envelope.
// ----------------------------------------------------------------------------
// A request is held in the input register, then in the result register that drives the output.
// Throughput: one request per cycle while the output is not stalled, set by the single-pass state update.
// Input register and result register both advance when the result is free
// or being taken, so an output stall holds back new requests only once both are full.
// Reset (rst_n low, asynchronous): all channel state cleared, LFSR to all
// ones, both pipeline registers empty.
module noise_channel_lfsr_envelope (
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] write_data, [15:8] cycles
    input  logic [4:0]  s_axis_tuser,   // [2:0] operation, [4:3] reg_index
    // master side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [3:0] sample, [11:4] read_data,
                                        // [12] write_claimed, [13] channel_on,
                                        // [15:14] zero
    output logic [0:0]  m_axis_tuser    // [0] read_valid
);
    import ncle_pkg::*;

    // ---------------- input register ----------------
    logic       in_valid_reg;
    logic [2:0] op_reg;
    logic [1:0] idx_reg;
    logic [7:0] wdata_reg;
    logic [7:0] cyc_reg;

    logic s_accept;
    logic adv;          // request moves from input register to result register
    logic out_valid_reg;

    assign adv           = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || adv;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            op_reg    <= s_axis_tuser[2:0];
            idx_reg   <= s_axis_tuser[4:3];
            wdata_reg <= s_axis_tdata[7:0];
            cyc_reg   <= s_axis_tdata[15:8];
        end
    end

    // ---------------- channel state ----------------
    logic [7:0]  length_reg,       length_next;
    logic [7:0]  envelope_reg,     envelope_next;
    logic [7:0]  freq_random_reg,  freq_random_next;
    logic [7:0]  control_reg,      control_next;
    logic        enabled_reg,      enabled_next;
    logic [15:0] shift_reg,        shift_next;
    logic [31:0] divider_count_reg, divider_count_next;
    logic [6:0]  length_count_reg, length_count_next;
    logic [3:0]  envelope_count_reg, envelope_count_next;
    logic [3:0]  volume_reg,       volume_next;
    logic        vol_changing_reg, vol_changing_next;

    logic [7:0]  rdata;
    logic        rvalid;
    logic        claimed;
    logic [6:0]  len_inc;
    logic [3:0]  env_inc;
    logic [2:0]  pace;
    logic        trigger;
    div_res_t    div_res;

    ncle_divider u_divider (
        .count       (divider_count_reg),
        .cycles      (cyc_reg),
        .freq_random (freq_random_reg),
        .res         (div_res)
    );

    assign len_inc = length_count_reg + 7'd1;
    assign env_inc = envelope_count_reg + 4'd1;
    assign pace    = envelope_reg[2:0];
    assign trigger = (op_reg == OP_WRITE) && (idx_reg == REG_CONTROL) && wdata_reg[7];

    always_comb
    begin
        length_next         = length_reg;
        envelope_next       = envelope_reg;
        freq_random_next    = freq_random_reg;
        control_next        = control_reg;
        enabled_next        = enabled_reg;
        shift_next          = shift_reg;
        divider_count_next  = divider_count_reg;
        length_count_next   = length_count_reg;
        envelope_count_next = envelope_count_reg;
        volume_next         = volume_reg;
        vol_changing_next   = vol_changing_reg;
        rdata               = 8'd0;
        rvalid              = 1'b0;
        claimed             = 1'b0;

        unique case (op_reg)
            OP_WRITE:
            begin
                unique case (idx_reg)
                    REG_LENGTH:
                    begin
                        length_next       = wdata_reg;
                        length_count_next = {1'b0, wdata_reg[5:0]};
                        claimed           = 1'b1;
                    end
                    REG_ENVELOPE:
                    begin
                        envelope_next = wdata_reg;
                        // DAC off: no bits in the volume/direction field
                        if ((wdata_reg & DAC_MASK) == 8'd0)
                        begin
                            enabled_next = 1'b0;
                        end
                        claimed = 1'b1;
                    end
                    REG_FREQ:
                    begin
                        freq_random_next = wdata_reg;
                    end
                    default:
                    begin
                        control_next = wdata_reg;
                        // trigger fires even with the DAC off
                        if (wdata_reg[7])
                        begin
                            enabled_next      = 1'b1;
                            volume_next       = envelope_reg[7:4];
                            vol_changing_next = 1'b1;
                            shift_next        = LFSR_SEED;
                        end
                        claimed = 1'b1;
                    end
                endcase
            end
            OP_READ:
            begin
                if (idx_reg == REG_CONTROL)
                begin
                    rdata  = control_reg & READ_MASK;
                    rvalid = 1'b1;
                end
            end
            OP_ADVANCE:
            begin
                if (enabled_reg)
                begin
                    divider_count_next = div_res.count_next;
                    if (div_res.step)
                    begin
                        shift_next = lfsr_step(shift_reg, freq_random_reg[3]);
                    end
                end
            end
            OP_LEN_TICK:
            begin
                // counts only with length enable set, on or off
                if (control_reg[6])
                begin
                    if (len_inc >= 7'(LENGTH_LIMIT))
                    begin
                        length_count_next = 7'd0;
                        enabled_next      = 1'b0;
                    end
                    else
                    begin
                        length_count_next = len_inc;
                    end
                end
            end
            OP_ENV_TICK:
            begin
                if (env_inc < {1'b0, pace})
                begin
                    envelope_count_next = env_inc;
                end
                else if ((pace == 3'd0) || !vol_changing_reg)
                begin
                    envelope_count_next = 4'd0;
                end
                else
                begin
                    envelope_count_next = env_inc - {1'b0, pace};
                    if (envelope_reg[3])
                    begin
                        if (volume_reg == VOLUME_MAX)
                        begin
                            vol_changing_next = 1'b0;
                        end
                        else
                        begin
                            volume_next = volume_reg + 4'd1;
                        end
                    end
                    else
                    begin
                        if (volume_reg == VOLUME_MIN)
                        begin
                            vol_changing_next = 1'b0;
                        end
                        else
                        begin
                            volume_next = volume_reg - 4'd1;
                        end
                    end
                end
            end
            default:
            begin
                // unused codes: state untouched, result carries the sample and channel_on only
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg         <= 8'd0;
            envelope_reg       <= 8'd0;
            freq_random_reg    <= 8'd0;
            control_reg        <= 8'd0;
            enabled_reg        <= 1'b0;
            shift_reg          <= LFSR_SEED;
            divider_count_reg  <= 32'd0;
            length_count_reg   <= 7'd0;
            envelope_count_reg <= 4'd0;
            volume_reg         <= 4'd0;
            vol_changing_reg   <= 1'b0;
        end
        else if (adv)
        begin
            length_reg         <= length_next;
            envelope_reg       <= envelope_next;
            freq_random_reg    <= freq_random_next;
            control_reg        <= control_next;
            enabled_reg        <= enabled_next;
            shift_reg          <= shift_next;
            divider_count_reg  <= divider_count_next;
            length_count_reg   <= length_count_next;
            envelope_count_reg <= envelope_count_next;
            volume_reg         <= volume_next;
            vol_changing_reg   <= vol_changing_next;
        end
    end

    // ---------------- result register ----------------
    logic [3:0]  sample;
    logic [15:0] out_data_reg;
    logic        out_rvalid_reg;

    // silent when off or when LFSR bit 0 is set
    assign sample = (enabled_next && !shift_next[0]) ? volume_next : 4'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg   <= {2'b00, enabled_next, claimed, rdata, sample};
            out_rvalid_reg <= rvalid;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_rvalid_reg;

    // ---------------- assertions ----------------
`include "noise_channel_lfsr_envelope_assert.svh"

    // a sounding sample only comes from a channel that is on
    `NCLE_ASSERT_NOW(a_sample_needs_on, m_axis_tvalid && (m_axis_tdata[3:0] != 4'd0), m_axis_tdata[13])
    // read data is nonzero only on an answered read, and only bit 6
    `NCLE_ASSERT_NOW(a_rdata_masked, m_axis_tvalid, (m_axis_tdata[11:4] & ~READ_MASK) == 8'd0 && (m_axis_tuser[0] || m_axis_tdata[11:4] == 8'd0))
    // a trigger leaves the channel on with a reseeded LFSR
    `NCLE_ASSERT_NEXT(a_trigger_seeds, adv && trigger, enabled_reg && (shift_reg == LFSR_SEED))
    // only a trigger turns the channel on
    `NCLE_ASSERT_NEXT(a_on_by_trigger, !enabled_reg && !(adv && trigger), !enabled_reg)
    // length counter never holds the full count
    `NCLE_ASSERT_NOW(a_length_range, 1'b1, length_count_reg < 7'd64)

endmodule

// ===== sv/ncle_divider.sv =====
// ----------------------------------------------------------------------------
// ncle_divider
// Frequency divider update: saturating accumulate, period compare, reload.
// ----------------------------------------------------------------------------
module ncle_divider (
    input  logic [31:0]        count,
    input  logic [7:0]         cycles,
    input  logic [7:0]         freq_random,
    output ncle_pkg::div_res_t res
);
    import ncle_pkg::*;

    logic [31:0] period;
    logic [32:0] sum;
    logic [31:0] sat;

    // table entry shifted by the clock shift nibble, at most 22 bits wide
    assign period = {25'd0, divisor(freq_random[2:0])} << freq_random[7:4];
    assign sum    = {1'b0, count} + {25'd0, cycles};
    assign sat    = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

    always_comb
    begin
        res.step       = (sat >= period);
        res.count_next = res.step ? (sat - period) : sat;
    end

endmodule
